>>> sv/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants of the UTF-16/UTF-32 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

	localparam logic [2:0] ENC_AUTO  = 3'd0;
	localparam logic [2:0] ENC_UTF8  = 3'd1;
	localparam logic [2:0] ENC_U16LE = 3'd2;
	localparam logic [2:0] ENC_U16BE = 3'd3;
	localparam logic [2:0] ENC_U32LE = 3'd4;
	localparam logic [2:0] ENC_U32BE = 3'd5;

	localparam int Q_DEPTH = 4;

	localparam int CFG_AW = 3;
	localparam logic [CFG_AW-3:0] CFG_MODE_IDX = '0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} src_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
		logic       bad_surrogate;
		logic [2:0] detected_encoding;
	} dst_beat_t;

	// One symbol (raw byte or code point) plus an optional end marker.
	typedef struct packed {
		logic        has_sym;
		logic [1:0]  sym_len;
		logic [25:0] cp;
		logic        marker;
		logic        bad;
		logic        ending;
		logic        step_last;
		logic [2:0]  enc;
	} job_t;

endpackage

>>> sv/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts input beats, holds and classifies the stream head, assembles
// units and joins surrogate pairs; emits one job per symbol or bare end marker.
// ----------------------------------------------------------------------------
module u2u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  u2u8_pkg::src_beat_t src_data,
	input  logic [2:0]          mode,
	input  logic                q_full,
	output logic                push,
	output u2u8_pkg::job_t      push_job
);
	import u2u8_pkg::*;

	typedef enum logic [1:0] {
		FE_RUN   = 2'b01,
		FE_FLUSH = 2'b10
	} fe_state_t;

	typedef enum logic [1:0] {
		FS_GO,
		FS_END,
		FS_BAD
	} feed_st_t;

	typedef struct packed {
		logic [2:0] enc;
		logic [2:0] skip;
	} detect_t;

	function automatic detect_t detect(input logic [7:0] h0, input logic [7:0] h1,
		input logic [7:0] h2, input logic [7:0] h3);
		detect_t r;
		r.enc  = ENC_UTF8;
		r.skip = 3'd0;
		if (h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF) begin
			r.enc  = ENC_U32BE;
			r.skip = 3'd4;
		end else if (h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00) begin
			r.enc  = ENC_U32LE;
			r.skip = 3'd4;
		end else if (h0 == 8'hFE && h1 == 8'hFF) begin
			r.enc  = ENC_U16BE;
			r.skip = 3'd2;
		end else if (h0 == 8'hFF && h1 == 8'hFE) begin
			r.enc  = ENC_U16LE;
			r.skip = 3'd2;
		end else if (h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF) begin
			r.enc  = ENC_UTF8;
			r.skip = 3'd3;
		end else if (h0 == 8'h00 && h1 == 8'h00 && h2 == 8'h00) begin
			r.enc = ENC_U32BE;
		end else if (h1 == 8'h00 && h2 == 8'h00 && h3 == 8'h00) begin
			r.enc = ENC_U32LE;
		end else if (h0 == 8'h00 && h2 == 8'h00) begin
			r.enc = ENC_U16BE;
		end else if (h1 == 8'h00 && h3 == 8'h00) begin
			r.enc = ENC_U16LE;
		end
		return r;
	endfunction

	fe_state_t   state_q;
	logic [7:0]  head_q [4];
	logic [2:0]  head_cnt_q;
	logic [2:0]  act_q;
	logic [23:0] unit_q;
	logic [1:0]  phase_q;
	logic [9:0]  hi_q;
	logic        pend_q;
	logic        halt_q;
	logic [1:0]  fidx_q;
	logic [1:0]  fend_q;
	logic        flast_q;
	logic        any_q;

	logic        src_take;
	logic        flush_go;
	logic        is_explicit;
	detect_t     det;
	logic        f_en;
	logic [7:0]  f_b;
	logic [2:0]  f_act;
	logic        f_last;
	logic        f_any;
	logic        head_en;
	logic        mk_only;

	feed_st_t    st;
	logic        sym;
	logic        raw;
	logic [31:0] cp32;
	logic [15:0] u16;
	logic        is16;
	logic [23:0] nx_unit;
	logic [1:0]  nx_phase;
	logic [9:0]  nx_hi;
	logic        nx_pend;

	logic        f_final;
	logic        any_n;
	logic        ending_f;
	logic        marker_f;
	logic        bad_f;
	logic        step_end;
	logic        clear;
	logic [1:0]  len_code;

	always_comb begin
		src_take    = (state_q == FE_RUN) && src_valid && !q_full;
		flush_go    = (state_q == FE_FLUSH) && !q_full;
		is_explicit = (mode >= ENC_UTF8) && (mode <= ENC_U32BE);
		det         = detect(head_q[0], head_q[1], head_q[2], src_data.in_byte);
		f_en        = 1'b0;
		f_b         = src_data.in_byte;
		f_act       = act_q;
		f_last      = src_data.in_last;
		f_any       = 1'b0;
		head_en     = 1'b0;
		mk_only     = 1'b0;
		if (flush_go) begin
			f_en   = 1'b1;
			f_b    = head_q[fidx_q];
			f_last = flast_q;
			f_any  = any_q;
		end else if (src_take && !halt_q) begin
			if (act_q != ENC_AUTO) begin
				f_en = 1'b1;
			end else if (is_explicit) begin
				f_en  = 1'b1;
				f_act = mode;
			end else begin
				head_en = 1'b1;
				if (head_cnt_q == 3'd3 && det.skip == 3'd4 && src_data.in_last) begin
					mk_only = 1'b1;
				end
			end
		end
	end

	always_comb begin
		nx_unit  = unit_q;
		nx_phase = phase_q;
		nx_hi    = hi_q;
		nx_pend  = pend_q;
		st       = FS_GO;
		sym      = 1'b0;
		raw      = 1'b0;
		cp32     = 32'd0;
		is16     = 1'b0;
		u16      = 16'd0;
		case (f_act)
			ENC_U16LE, ENC_U16BE: begin
				if (phase_q == 2'd0) begin
					nx_unit  = {16'd0, f_b};
					nx_phase = 2'd1;
				end else begin
					is16     = 1'b1;
					u16      = (f_act == ENC_U16LE) ? {f_b, unit_q[7:0]} : {unit_q[7:0], f_b};
					nx_unit  = 24'd0;
					nx_phase = 2'd0;
				end
			end
			ENC_U32LE, ENC_U32BE: begin
				if (phase_q != 2'd3) begin
					if (f_act == ENC_U32LE) begin
						case (phase_q)
							2'd0: nx_unit[7:0] = f_b;
							2'd1: nx_unit[15:8] = f_b;
							default: nx_unit[23:16] = f_b;
						endcase
					end else begin
						nx_unit = {unit_q[15:0], f_b};
					end
					nx_phase = phase_q + 2'd1;
				end else begin
					cp32     = (f_act == ENC_U32LE) ? {f_b, unit_q} : {unit_q, f_b};
					nx_unit  = 24'd0;
					nx_phase = 2'd0;
					if (cp32 == 32'd0) begin
						st = FS_END;
					end else begin
						sym = 1'b1;
					end
				end
			end
			default: begin
				if (f_b == 8'd0) begin
					st = FS_END;
				end else begin
					sym  = 1'b1;
					raw  = 1'b1;
					cp32 = {24'd0, f_b};
				end
			end
		endcase
		if (is16) begin
			if (pend_q) begin
				if (u16[15:10] == 6'b110111) begin
					cp32    = 32'h10000 + {12'd0, hi_q, u16[9:0]};
					sym     = 1'b1;
					nx_pend = 1'b0;
					nx_hi   = 10'd0;
				end else begin
					st = FS_BAD;
				end
			end else if (u16 == 16'd0) begin
				st = FS_END;
			end else if (u16[15:10] == 6'b110110) begin
				nx_hi   = u16[9:0];
				nx_pend = 1'b1;
			end else begin
				cp32 = {16'd0, u16};
				sym  = 1'b1;
			end
		end
	end

	always_comb begin
		if (raw || cp32 < 32'h80) begin
			len_code = 2'd0;
		end else if (cp32 < 32'h800) begin
			len_code = 2'd1;
		end else if (cp32 < 32'h10000) begin
			len_code = 2'd2;
		end else begin
			len_code = 2'd3;
		end
		f_final  = flush_go ? ((fidx_q == fend_q) || (st != FS_GO)) : 1'b1;
		any_n    = f_any || sym;
		ending_f = f_final && ((st != FS_GO) || f_last);
		marker_f = f_final && ((st != FS_GO) || (f_last && (nx_pend || !any_n)));
		bad_f    = f_final && ((st == FS_BAD) || ((st == FS_GO) && f_last && nx_pend));
		step_end = (f_en && ending_f) || mk_only;
		clear    = (step_end && f_last) || (src_take && halt_q && src_data.in_last);

		push               = (f_en && (sym || marker_f)) || mk_only;
		push_job.has_sym   = f_en && sym;
		push_job.sym_len   = len_code;
		push_job.cp        = cp32[25:0];
		push_job.marker    = mk_only || marker_f;
		push_job.bad       = !mk_only && bad_f;
		push_job.ending    = mk_only || ending_f;
		push_job.step_last = mk_only || f_final;
		push_job.enc       = mk_only ? (det.enc - 3'd1) : (f_act - 3'd1);
	end

	assign src_stall = !((state_q == FE_RUN) && !q_full);

	always_ff @(posedge clk) begin
		if (head_en) begin
			head_q[head_cnt_q[1:0]] <= src_data.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FE_RUN;
			head_cnt_q <= 3'd0;
			act_q      <= ENC_AUTO;
			unit_q     <= 24'd0;
			phase_q    <= 2'd0;
			hi_q       <= 10'd0;
			pend_q     <= 1'b0;
			halt_q     <= 1'b0;
			fidx_q     <= 2'd0;
			fend_q     <= 2'd0;
			flast_q    <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			if (f_en) begin
				unit_q  <= nx_unit;
				phase_q <= nx_phase;
				hi_q    <= nx_hi;
				pend_q  <= nx_pend;
			end
			if (flush_go) begin
				fidx_q <= fidx_q + 2'd1;
				any_q  <= any_n;
				if (f_final) begin
					state_q <= FE_RUN;
				end
			end
			if (src_take && !halt_q && act_q == ENC_AUTO && is_explicit) begin
				act_q <= mode;
			end
			if (head_en) begin
				head_cnt_q <= head_cnt_q + 3'd1;
				if (head_cnt_q == 3'd3) begin
					act_q <= det.enc;
					if (det.skip != 3'd4) begin
						state_q <= FE_FLUSH;
						fidx_q  <= det.skip[1:0];
						fend_q  <= 2'd3;
						flast_q <= src_data.in_last;
						any_q   <= 1'b0;
					end
				end else if (src_data.in_last) begin
					act_q   <= ENC_UTF8;
					state_q <= FE_FLUSH;
					fidx_q  <= 2'd0;
					fend_q  <= head_cnt_q[1:0];
					flast_q <= 1'b1;
					any_q   <= 1'b0;
				end
			end
			if (step_end && !f_last) begin
				halt_q <= 1'b1;
			end
			if (clear) begin
				state_q    <= FE_RUN;
				head_cnt_q <= 3'd0;
				act_q      <= ENC_AUTO;
				unit_q     <= 24'd0;
				phase_q    <= 2'd0;
				hi_q       <= 10'd0;
				pend_q     <= 1'b0;
				halt_q     <= 1'b0;
			end
		end
	end

	a_flush_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FE_FLUSH) |-> (!halt_q && act_q != ENC_AUTO))
		else $error("head replay while halted or undecided");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> !f_en)
		else $error("unit decoded after stream end");

endmodule

>>> sv/u2u8_queue.sv
// ----------------------------------------------------------------------------
// u2u8_queue
// Short job queue between the decode front and the byte emitter.
// ----------------------------------------------------------------------------
module u2u8_queue #(
	parameter int DEPTH = u2u8_pkg::Q_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  u2u8_pkg::job_t push_job,
	output logic           full,
	output logic           pop_valid,
	output u2u8_pkg::job_t pop_job,
	input  logic           pop
);
	import u2u8_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CW'(1);
				2'b01: cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

>>> sv/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Turns jobs into UTF-8 bytes and end markers, one beat a cycle unless stalled.
// ----------------------------------------------------------------------------
module u2u8_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  u2u8_pkg::job_t      pop_job,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output u2u8_pkg::dst_beat_t dst_data
);
	import u2u8_pkg::*;

	job_t      cur_q;
	logic      cur_v_q;
	logic [2:0] idx_q;
	logic      dst_v_q;
	dst_beat_t dst_q;

	logic [2:0] n_sym;
	logic [2:0] n_tot;
	logic       is_fin;
	logic       out_free;
	logic       fire;
	logic       done;
	logic [1:0] rem;
	logic [7:0] data_byte;
	dst_beat_t  beat;

	always_comb begin
		n_sym    = cur_q.has_sym ? (3'({1'b0, cur_q.sym_len}) + 3'd1) : 3'd0;
		n_tot    = n_sym + {2'd0, cur_q.marker};
		is_fin   = (idx_q == n_tot - 3'd1);
		out_free = !dst_v_q || !dst_stall;
		fire     = cur_v_q && out_free;
		done     = fire && is_fin;
		pop      = pop_valid && (!cur_v_q || done);
		rem      = cur_q.sym_len - idx_q[1:0];

		if (idx_q == 3'd0) begin
			case (cur_q.sym_len)
				2'd0: data_byte = cur_q.cp[7:0];
				2'd1: data_byte = {3'b110, cur_q.cp[10:6]};
				2'd2: data_byte = {4'b1110, cur_q.cp[15:12]};
				default: data_byte = 8'hF0 | cur_q.cp[25:18];
			endcase
		end else begin
			case (rem)
				2'd0: data_byte = {2'b10, cur_q.cp[5:0]};
				2'd1: data_byte = {2'b10, cur_q.cp[11:6]};
				default: data_byte = {2'b10, cur_q.cp[17:12]};
			endcase
		end

		if (idx_q < n_sym) begin
			beat.out_byte   = data_byte;
			beat.byte_valid = 1'b1;
		end else begin
			beat.out_byte   = 8'd0;
			beat.byte_valid = 1'b0;
		end
		beat.run_last          = is_fin && cur_q.step_last;
		beat.stream_end        = is_fin && cur_q.ending;
		beat.bad_surrogate     = is_fin && cur_q.bad;
		beat.detected_encoding = cur_q.enc;
	end

	assign dst_valid = dst_v_q;
	assign dst_data  = dst_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_job;
		end
		if (out_free && fire) begin
			dst_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 3'd0;
			dst_v_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
				idx_q   <= 3'd0;
			end else if (done) begin
				cur_v_q <= 1'b0;
			end else if (fire) begin
				idx_q <= idx_q + 3'd1;
			end
			if (out_free) begin
				dst_v_q <= fire;
			end
		end
	end

	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && !dst_data.byte_valid) |-> (dst_data.out_byte == 8'd0 && dst_data.run_last))
		else $error("end marker malformed");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.stream_end) |-> dst_data.run_last)
		else $error("stream end not on last beat of run");

	a_bad_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.bad_surrogate) |-> (!dst_data.byte_valid && dst_data.stream_end))
		else $error("bad surrogate flag outside end marker");

endmodule

>>> sv/utf16_utf32_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_utf32_to_utf8_transcoder
// Byte-stream transcoder from UTF-16/UTF-32 (either byte order) or UTF-8 to
// UTF-8, with BOM and zero-byte encoding detection.
//
// src channel: one raw byte per beat, in_last on the final byte of a stream.
// dst channel: one UTF-8 byte per beat, or an end-only marker (byte_valid 0);
//   run_last closes the beats caused by one input beat, stream_end closes
//   the stream, bad_surrogate flags a broken surrogate pair.
// APB port: register encoding_mode at address 0, sampled on the first byte
//   of each stream; write it only while the block is idle.
// Throughput: one input beat per cycle while the job queue has room and one
//   output beat per cycle; each job passes the queue, the emitter's job
//   register and the registered dst port, and holds the emitter until its
//   bytes have left. In auto mode the fourth byte, or an earlier final byte,
//   replays the held head bytes after any BOM, up to four, one per cycle
//   while the queue has room, with src_stall high.
// Reset: clears the mode register and all stream state; no clearing pass.
// A stalled dst beat holds; the four-entry queue fills and src_stall rises.
// ----------------------------------------------------------------------------
module utf16_utf32_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = u2u8_pkg::Q_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [u2u8_pkg::CFG_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  u2u8_pkg::src_beat_t           src_data,
	output logic                          dst_valid,
	input  logic                          dst_stall,
	output u2u8_pkg::dst_beat_t           dst_data
);
	import u2u8_pkg::*;

	logic [2:0] mode_q;
	logic       sel_mode;
	logic       q_full;
	logic       push;
	job_t       push_job;
	logic       pop_valid;
	job_t       pop_job;
	logic       pop;

	assign pready   = 1'b1;
	assign sel_mode = (paddr[CFG_AW-1:2] == CFG_MODE_IDX) && (paddr[1:0] == 2'd0);
	assign prdata   = sel_mode ? {29'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ENC_AUTO;
		end else if (psel && penable && pwrite && pready
			&& paddr[CFG_AW-1:2] == CFG_MODE_IDX) begin
			mode_q <= pwdata[2:0];
		end
	end

	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.mode      (mode_q),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	u2u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop       (pop)
	);

	u2u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule
